// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/aesctr_pkg.sv =====
package aesctr_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int NUM_ROUNDS   = 10;
    localparam int RND_W        = 4;

    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic                  capture;
        logic                  start;
        logic                  round;
        logic                  emit;
        logic [RND_W-1:0]      rnd;
        logic [IDX_W-1:0]      index;
        logic                  last;
    } dp_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
        logic [7:0] v;
        case (r)
            4'd1:    v = 8'h01;
            4'd2:    v = 8'h02;
            4'd3:    v = 8'h04;
            4'd4:    v = 8'h08;
            4'd5:    v = 8'h10;
            4'd6:    v = 8'h20;
            4'd7:    v = 8'h40;
            4'd8:    v = 8'h80;
            4'd9:    v = 8'h1b;
            4'd10:   v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits [127-8i -: 8]
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 8*(r + 4*c) -: 8] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0  = s[127 - 32*c -: 8];
            a1  = s[119 - 32*c -: 8];
            a2  = s[111 - 32*c -: 8];
            a3  = s[103 - 32*c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0]  w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// ===== rtl/aesctr_ctrl.sv =====
module aesctr_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [6:0]                block_count,
    output logic                      out_valid,
    input  logic                      out_ready,
    output aesctr_pkg::dp_cmd_t       cmd
);

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_LOAD  = 3'b010,
        ST_ROUND = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [aesctr_pkg::CNT_W-1:0]        remain_reg, remain_next;
    logic [aesctr_pkg::IDX_W-1:0]        index_reg, index_next;
    logic [aesctr_pkg::RND_W-1:0]        rnd_reg, rnd_next;
    logic                                out_valid_reg, out_valid_next;
    logic [aesctr_pkg::CNT_W-1:0]        count_sat;
    logic                                out_free;

    always_comb
    begin
        if (block_count > 7'(aesctr_pkg::MAX_BLOCKS))
            count_sat = aesctr_pkg::CNT_W'(aesctr_pkg::MAX_BLOCKS);
        else
            count_sat = aesctr_pkg::CNT_W'(block_count);
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        index_next     = index_reg;
        rnd_next       = rnd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.rnd        = rnd_reg;
        cmd.index      = index_reg;
        cmd.last       = (remain_reg == aesctr_pkg::CNT_W'(1));
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    remain_next = count_sat;
                    index_next  = '0;
                    if (count_sat != '0)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.start  = 1'b1;
                rnd_next   = aesctr_pkg::RND_W'(1);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rnd_reg != aesctr_pkg::RND_W'(aesctr_pkg::NUM_ROUNDS))
                begin
                    cmd.round = 1'b1;
                    rnd_next  = rnd_reg + 1'b1;
                end
                else if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    index_next     = index_reg + 1'b1;
                    state_next     = cmd.last ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            index_reg     <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            index_reg     <= index_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/aesctr_dp.sv =====
module aesctr_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [63:0]                         cfg_data,
    input  logic [63:0]                         nonce,
    input  aesctr_pkg::dp_cmd_t                 cmd,
    output logic [63:0]                         stream_high,
    output logic [63:0]                         stream_low,
    output logic [aesctr_pkg::IDX_W-1:0]        block_number,
    output logic                                last_block
);

    logic [63:0]                         key_high_reg, key_low_reg;
    logic [63:0]                         nonce_reg;
    logic [127:0]                        blk_reg, blk_next;
    logic [127:0]                        rk_reg, rk_next;
    logic [127:0]                        key;
    logic [127:0]                        ss;
    logic [127:0]                        ctr;
    logic [127:0]                        out_reg;
    logic [aesctr_pkg::IDX_W-1:0]        num_reg;
    logic                                last_reg;

    assign key = {key_high_reg, key_low_reg};
    assign ss  = aesctr_pkg::sub_shift(blk_reg);
    assign ctr = {nonce_reg, 56'd0, {(8 - aesctr_pkg::IDX_W){1'b0}}, cmd.index};

    always_comb
    begin
        blk_next = blk_reg;
        rk_next  = rk_reg;
        if (cmd.start)
        begin
            blk_next = ctr ^ key;
            rk_next  = aesctr_pkg::key_step(key, aesctr_pkg::rcon(aesctr_pkg::RND_W'(1)));
        end
        else if (cmd.round)
        begin
            blk_next = aesctr_pkg::mix_columns(ss) ^ rk_reg;
            rk_next  = aesctr_pkg::key_step(rk_reg, aesctr_pkg::rcon(cmd.rnd + 1'b1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aesctr_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                aesctr_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:                  key_low_reg  <= key_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        rk_reg  <= rk_next;
        if (cmd.capture)
            nonce_reg <= nonce;
        if (cmd.emit)
        begin
            out_reg  <= ss ^ rk_reg;
            num_reg  <= cmd.index;
            last_reg <= cmd.last;
        end
    end

    assign stream_high  = out_reg[127:64];
    assign stream_low   = out_reg[63:0];
    assign block_number = num_reg;
    assign last_block   = last_reg;

endmodule

// ===== rtl/aes128_ctr_keystream_top.sv =====
// channel   dir  handshake              payload
// cfg       in   cfg_we                 cfg_index, cfg_data
// in        in   in_valid / in_ready    nonce, block_count
// out       out  out_valid / out_ready  stream_high, stream_low, block_number, last_block
//
// Each block is a load with key whitening, nine full rounds, then the final round written
// straight into the output register. Accepting a request first captures the nonce.
// The round keys are expanded on the fly alongside the rounds, one step per cycle.
// A request is taken only when idle; a count of zero gives no blocks, above 64 gives 64.
// The output register holds a block while the next one is computed; the last round stalls
// while it is still full. Reset is asynchronous; the key resets to zero.
module aes128_ctr_keystream_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  nonce,
    input  logic [6:0]   block_count,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  stream_high,
    output logic [63:0]  stream_low,
    output logic [5:0]   block_number,
    output logic         last_block
);

    aesctr_pkg::dp_cmd_t cmd;

    aesctr_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .block_count (block_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    aesctr_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .nonce        (nonce),
        .cmd          (cmd),
        .stream_high  (stream_high),
        .stream_low   (stream_low),
        .block_number (block_number),
        .last_block   (last_block)
    );

endmodule

// ===== rtl/aesctr_checker.sv =====
`include "assert_macros.svh"

module aesctr_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [6:0]   block_count,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [63:0]  stream_high,
    input  logic         last_block
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(stream_high))
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready && block_count != 7'd0, !in_ready)
    `ASSERT_NEXT(a_busy_mid_stream, clk, rst_n, out_valid && out_ready && !last_block, !in_ready || (out_valid && last_block))
    `ASSERT_SAME(a_idle_no_partial, clk, rst_n, in_ready && out_valid, last_block)

endmodule

bind aes128_ctr_keystream_top aesctr_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .block_count (block_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stream_high (stream_high),
    .last_block  (last_block)
);

// ===== sim/tb.sv =====
module tb;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [5:0]  num;
        logic        last;
    } ks_block_t;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 20000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic [63:0]  cfg_data;
    logic         in_valid;
    logic         in_ready;
    logic [63:0]  nonce;
    logic [6:0]   block_count;
    logic         out_valid;
    logic         out_ready;
    logic [63:0]  stream_high;
    logic [63:0]  stream_low;
    logic [5:0]   block_number;
    logic         last_block;

    aes128_ctr_keystream_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .nonce        (nonce),
        .block_count  (block_count),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .stream_high  (stream_high),
        .stream_low   (stream_low),
        .block_number (block_number),
        .last_block   (last_block)
    );

    logic [7:0]  sb [256];
    logic [63:0] key_hi, key_lo;
    logic [127:0] rkeys [11];
    ks_block_t   pending_blocks [$];
    int          errors, requests_sent, blocks_seen, idle_cycles;
    bit          long_hold, stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // own copy of the S-box
    initial
    begin
        logic [7:0] p, q, x;
        p = 8'h01;
        q = 8'h01;
        sb[0] = 8'h63;
        do
        begin
            p = p ^ (p << 1) ^ ((p & 8'h80) ? 8'h1b : 8'h00);
            q = q ^ (q << 1);
            q = q ^ (q << 2);
            q = q ^ (q << 4);
            if (q & 8'h80) q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
            sb[p] = x ^ 8'h63;
        end
        while (p != 8'h01);
    end

    function automatic logic [7:0] gf2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] bget(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    task automatic schedule_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rc;
        logic [127:0] k;
        k = {key_hi, key_lo};
        for (int i = 0; i < 4; i++) w[i] = k[127 - 32*i -: 32];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
                rc = gf2(rc);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] encrypt_counter(input logic [127:0] blk);
        logic [127:0] s, t;
        logic [7:0] a0, a1, a2, a3, al;
        s = blk ^ rkeys[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[127 - 8*(w + 4*c) -: 8] = sb[bget(s, w + 4*((c + w) % 4))];
            s = t;
            if (r != 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = bget(s, 4*c); a1 = bget(s, 4*c+1);
                    a2 = bget(s, 4*c+2); a3 = bget(s, 4*c+3);
                    al = a0 ^ a1 ^ a2 ^ a3;
                    t[127 - 32*c -: 8] = a0 ^ al ^ gf2(a0 ^ a1);
                    t[119 - 32*c -: 8] = a1 ^ al ^ gf2(a1 ^ a2);
                    t[111 - 32*c -: 8] = a2 ^ al ^ gf2(a2 ^ a3);
                    t[103 - 32*c -: 8] = a3 ^ al ^ gf2(a3 ^ a0);
                    s = t;
                end
            s = s ^ rkeys[r];
        end
        return s;
    endfunction

    task automatic predict_keystream(input logic [63:0] n, input logic [6:0] cnt);
        int c;
        ks_block_t b;
        logic [127:0] ct;
        c = (cnt > aesctr_pkg::MAX_BLOCKS) ? aesctr_pkg::MAX_BLOCKS : cnt;
        for (int i = 0; i < c; i++)
        begin
            ct = encrypt_counter({n, 56'd0, 8'(i)});
            b.hi = ct[127:64];
            b.lo = ct[63:0];
            b.num = 6'(i);
            b.last = (i == c - 1);
            pending_blocks.push_back(b);
        end
    endtask

    task automatic write_key(input logic idx, input logic [63:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == aesctr_pkg::CFG_KEY_HIGH) key_hi = v;
        else key_lo = v;
        schedule_keys();
    endtask

    // caller is at a falling edge; returns at a falling edge after acceptance with
    // valid still high, so the next request can follow straight on
    task automatic send_request(input logic [63:0] n, input logic [6:0] cnt);
        in_valid <= 1'b1;
        nonce <= n;
        block_count <= cnt;
        do @(posedge clk); while (!in_ready);
        predict_keystream(n, cnt);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
    endtask

    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13) return 7'($urandom_range(1, 4));
        if (r < 16) return 7'($urandom_range(5, 64));
        if (r == 16) return 7'd0;
        if (r == 17) return 7'($urandom_range(65, 127));
        return 7'd64;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        @(negedge clk);
        send_request(64'd0, 7'd1);
        send_request(64'hffff_ffff_ffff_ffff, 7'd2);
        send_request(64'h0123_4567_89ab_cdef, 7'd0);
        send_request(64'h8000_0000_0000_0001, 7'd64);
        send_request(64'h5555_aaaa_5555_aaaa, 7'd127);
        send_request(64'haaaa_5555_aaaa_5555, 7'd65);
        send_request(64'hdead_beef_0000_0001, 7'd3);
        settle();
        write_key(aesctr_pkg::CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        write_key(aesctr_pkg::CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        @(negedge clk);
        send_request(64'd0, 7'd2);
        send_request(64'hffff_ffff_ffff_ffff, 7'd1);
        settle();
        write_key(aesctr_pkg::CFG_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
        write_key(aesctr_pkg::CFG_KEY_LOW, 64'habf7_1588_09cf_4f3c);
        @(negedge clk);
        send_request(64'hf0f1_f2f3_f4f5_f6f7, 7'd4);
        settle();
    endtask

    task automatic test_backpressure();
        @(negedge clk);
        long_hold = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_request(rnd64(), 7'($urandom_range(2, 8)));
        join
        settle();
    endtask

    task automatic test_random(input int n_items);
        @(negedge clk);
        for (int i = 0; i < n_items; i++)
        begin
            send_request(rnd64(), pick_count());
            random_gap();
        end
        settle();
    endtask

    task automatic test_keys_random();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_key(aesctr_pkg::CFG_KEY_HIGH, rnd64());
            write_key(aesctr_pkg::CFG_KEY_LOW, rnd64());
            test_random(100);
        end
        write_key(aesctr_pkg::CFG_KEY_HIGH, 64'd0);
        write_key(aesctr_pkg::CFG_KEY_LOW, 64'd0);
        test_random(40);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n) out_ready <= 1'b0;
        else if (long_hold) out_ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
            out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ks_block_t e;
        if (rst_n && out_valid && out_ready)
        begin
            blocks_seen++;
            if (pending_blocks.size() == 0)
            begin
                errors++;
                $display("%0t unexpected block: actual %h %h num %0d last %0b", $time,
                         stream_high, stream_low, block_number, last_block);
            end
            else
            begin
                e = pending_blocks.pop_front();
                if (e.hi !== stream_high || e.lo !== stream_low)
                begin
                    errors++;
                    $display("%0t stream mismatch: expected %h %h actual %h %h", $time,
                             e.hi, e.lo, stream_high, stream_low);
                end
                if (e.num !== block_number)
                begin
                    errors++;
                    $display("%0t block_number: expected %0d actual %0d", $time,
                             e.num, block_number);
                end
                if (e.last !== last_block)
                begin
                    errors++;
                    $display("%0t last_block: expected %0b actual %0b", $time,
                             e.last, last_block);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d blocks outstanding", pending_blocks.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        requests_sent = 0;
        blocks_seen = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        stall_mode = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aesctr_pkg::CFG_KEY_HIGH;
        cfg_data = 64'd0;
        in_valid = 1'b0;
        nonce = 64'd0;
        block_count = 7'd0;
        out_ready = 1'b0;
        key_hi = 64'd0;
        key_lo = 64'd0;
        #1;
        schedule_keys();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_keys_random();
        $display("covered %0d requests, %0d keystream blocks checked", requests_sent,
                 blocks_seen);
        $display("keys: zero, all ones, standard vector and random; backpressure hold");
        if (errors == 0 && pending_blocks.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
